FILE: rtl/bblru_pkg.sv
`default_nettype none

package bblru_pkg;

	localparam int unsigned ENTRIES_DEFAULT = 16;
	localparam logic [31:0] CAPACITY_RESET = 32'd1048576;

	// Request codes carried on the mode port.
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// One cached entry as it sits in a cell of the recency chain.
	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] size;
	} entry_t;

	// Operation broadcast to every cell of the chain at once.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_PUSH,
		CELL_PULL,
		CELL_DROP
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [31:0] key;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/byte_budget_lru_cache_policy.sv
// A lookup, clear or rejected insert gives its one result from the execute state.
// An insert gives one result per evicted entry from the evict state, then a last one.
// A new request is taken only in the idle state; busy is high while one is in progress.
// Reset clears the table, the counters and the budget (1048576 bytes) at once, no sweep.
// The receiver cannot stall: each result is shown for exactly one cycle while done is high.
`default_nettype none

module byte_budget_lru_cache_policy
	import bblru_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [31:0]                  cfg_wdata,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   mode,
	input  wire logic [31:0]                  key,
	input  wire logic [31:0]                  entry_size,
	output logic                              done,
	output logic                              hit,
	output logic                              rejected,
	output logic                              evicted_valid,
	output logic [31:0]                       evicted_key,
	output logic [$clog2(ENTRIES + 1) - 1:0]  entry_count,
	output logic [31:0]                       bytes_used,
	output logic                              last
);

	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned IW = $clog2(ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EVICT
	} state_t;

	// The cells form a recency-ordered list: cell 0 holds the most recent
	// entry and valid entries always fill a prefix of the chain, so the
	// least recent entry is the one in cell entry_count-1. An insert pushes
	// the whole chain down by one; removing a matched key pulls the cells
	// behind it up by one, which keeps the prefix contiguous.

	state_t      state_q;
	logic [31:0] cap_q;
	logic [1:0]  mode_q;
	logic [31:0] key_q;
	logic [31:0] size_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] bytes_q;

	logic        done_q;
	logic        hit_q;
	logic        rejected_q;
	logic        ev_valid_q;
	logic [31:0] ev_key_q;
	logic [CW-1:0] count_out_q;
	logic [31:0] bytes_out_q;
	logic        last_q;

	cell_ctrl_t          ctrl;
	logic [ENTRIES-1:0]  sel;
	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  rm_mask;
	logic [ENTRIES-1:0]  lru_sel;
	entry_t              ent [ENTRIES];
	entry_t              prv [ENTRIES];
	entry_t              nxt [ENTRIES];

	logic          any_match;
	logic [31:0]   match_size;
	logic [IW-1:0] lru_idx;
	entry_t        lru_ent;
	logic          too_big;
	logic          over_budget;
	logic          full;
	logic          must_evict;

	// Neighbor wiring of the chain: cell 0 is fed the new entry, the last
	// cell is fed an empty slot.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			prv[i] = (i == 0) ? entry_t'{valid: 1'b1, key: key_q, size: size_q} :
				ent[(i == 0) ? 0 : i - 1];
			nxt[i] = (i == ENTRIES - 1) ? entry_t'('0) : ent[(i == ENTRIES - 1) ? i : i + 1];
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		bblru_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sel    (sel[g]),
			.prev   (prv[g]),
			.next   (nxt[g]),
			.ent    (ent[g]),
			.match  (match[g])
		);
	end

	// Keys are unique in the table, so the match vector is one-hot or zero.
	// The pull mask covers the matched cell and every cell behind it.
	always_comb begin
		match_size = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_size = match_size | (match[i] ? ent[i].size : 32'd0);
		end
		for (int i = 0; i < ENTRIES; i++) begin
			rm_mask[i] = |(match & ((ENTRIES)'(2) << i) - (ENTRIES)'(1)) ;
		end
	end

	assign any_match = |match;
	assign lru_idx   = IW'(cnt_q - CW'(1));
	assign lru_ent   = ent[lru_idx];

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			lru_sel[i] = (lru_idx == IW'(i));
		end
	end

	// The sum of held bytes and the new size is compared at 33 bits so a
	// carry out of the 32-bit add counts as over budget.
	assign too_big     = size_q > cap_q;
	assign over_budget = ({1'b0, bytes_q} + {1'b0, size_q}) > {1'b0, cap_q};
	assign full        = cnt_q == CW'(ENTRIES);
	assign must_evict  = over_budget || full;

	always_comb begin
		ctrl.op  = CELL_HOLD;
		ctrl.key = key_q;
		sel      = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (mode_q == MODE_CLEAR) begin
					ctrl.op = CELL_CLEAR;
				end else if (mode_q == MODE_INSERT && !too_big && any_match) begin
					ctrl.op = CELL_PULL;
					sel     = rm_mask;
				end
			end
			ST_EVICT: begin
				if (must_evict) begin
					ctrl.op = CELL_DROP;
					sel     = lru_sel;
				end else begin
					ctrl.op = CELL_PUSH;
				end
			end
			default: ctrl.op = CELL_HOLD;
		endcase
	end

	// The budget register; the user must write it only while the block is idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_LOOKUP;
			key_q       <= '0;
			size_q      <= '0;
			cnt_q       <= '0;
			bytes_q     <= '0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			rejected_q  <= 1'b0;
			ev_valid_q  <= 1'b0;
			ev_key_q    <= '0;
			count_out_q <= '0;
			bytes_out_q <= '0;
			last_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						key_q   <= key;
						size_q  <= entry_size;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					hit_q       <= 1'b0;
					rejected_q  <= 1'b0;
					ev_valid_q  <= 1'b0;
					ev_key_q    <= '0;
					count_out_q <= cnt_q;
					bytes_out_q <= bytes_q;
					last_q      <= 1'b1;
					case (mode_q)
						MODE_LOOKUP: begin
							done_q  <= 1'b1;
							hit_q   <= any_match;
							state_q <= ST_IDLE;
						end
						MODE_CLEAR: begin
							done_q      <= 1'b1;
							cnt_q       <= '0;
							bytes_q     <= '0;
							count_out_q <= '0;
							bytes_out_q <= '0;
							state_q     <= ST_IDLE;
						end
						MODE_INSERT: begin
							if (too_big) begin
								done_q     <= 1'b1;
								rejected_q <= 1'b1;
								state_q    <= ST_IDLE;
							end else begin
								// An entry under the same key leaves silently.
								if (any_match) begin
									cnt_q   <= cnt_q - CW'(1);
									bytes_q <= bytes_q - match_size;
								end
								state_q <= ST_EVICT;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_EVICT: begin
					done_q     <= 1'b1;
					hit_q      <= 1'b0;
					rejected_q <= 1'b0;
					if (must_evict) begin
						// Evict the least recent entry and report it.
						cnt_q       <= cnt_q - CW'(1);
						bytes_q     <= bytes_q - lru_ent.size;
						count_out_q <= cnt_q - CW'(1);
						bytes_out_q <= bytes_q - lru_ent.size;
						ev_valid_q  <= 1'b1;
						ev_key_q    <= lru_ent.key;
						last_q      <= 1'b0;
					end else begin
						// The new entry fits and a cell is free: it goes in as most recent.
						cnt_q       <= cnt_q + CW'(1);
						bytes_q     <= bytes_q + size_q;
						count_out_q <= cnt_q + CW'(1);
						bytes_out_q <= bytes_q + size_q;
						ev_valid_q  <= 1'b0;
						ev_key_q    <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign done          = done_q;
	assign hit           = hit_q;
	assign rejected      = rejected_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_key   = ev_key_q;
	assign entry_count   = count_out_q;
	assign bytes_used    = bytes_out_q;
	assign last          = last_q;

endmodule

`default_nettype wire

FILE: rtl/bblru_cell.sv
`default_nettype none

module bblru_cell
	import bblru_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       sel,
	input  wire entry_t     prev,
	input  wire entry_t     next,
	output entry_t          ent,
	output logic            match
);

	logic        valid_q;
	logic [31:0] key_q;
	logic [31:0] size_q;
	entry_t      ent_n;

	assign ent   = '{valid: valid_q, key: key_q, size: size_q};
	assign match = valid_q && (key_q == ctrl.key);

	always_comb begin
		ent_n = ent;
		case (ctrl.op)
			CELL_CLEAR: ent_n.valid = 1'b0;
			CELL_PUSH:  ent_n = prev;
			CELL_PULL: begin
				if (sel) begin
					ent_n = next;
				end
			end
			CELL_DROP: begin
				if (sel) begin
					ent_n.valid = 1'b0;
				end
			end
			default: ent_n = ent;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_n.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= ent_n.key;
		size_q <= ent_n.size;
	end

endmodule

`default_nettype wire

FILE: tb/sv/byte_budget_lru_cache_policy_tb.sv
`timescale 1ns / 100ps

// Testbench for the byte-budget LRU replacement policy.
// Requests go in through the start/busy handshake. Each result the block
// strobes with done is compared, field by field, against the oldest outcome
// that the local predictor queued when the request was accepted.
module byte_budget_lru_cache_policy_tb;
	import bblru_pkg::*;

	localparam int NUM_SLOTS = ENTRIES_DEFAULT;
	// Cycles allowed once nothing is outstanding. Every request produces at
	// least one result, so this only covers the result register draining.
	localparam int SETTLE_CYCLES = 4;
	// Cycles in a row with neither a request nor a result accepted.
	localparam int STALL_LIMIT = 4000;

	// One result as the block reports it.
	typedef struct packed {
		logic        hit;
		logic        rejected;
		logic        evicted_valid;
		logic [31:0] evicted_key;
		logic [4:0]  entry_count;
		logic [31:0] bytes_used;
		logic        last;
	} cache_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        start = 1'b0;
	logic [1:0]  mode = MODE_LOOKUP;
	logic [31:0] key = '0;
	logic [31:0] entry_size = '0;
	logic        busy;
	logic        done;
	logic        hit;
	logic        rejected;
	logic        evicted_valid;
	logic [31:0] evicted_key;
	logic [4:0]  entry_count;
	logic [31:0] bytes_used;
	logic        last;

	byte_budget_lru_cache_policy #(
		.ENTRIES(NUM_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.mode(mode),
		.key(key),
		.entry_size(entry_size),
		.done(done),
		.hit(hit),
		.rejected(rejected),
		.evicted_valid(evicted_valid),
		.evicted_key(evicted_key),
		.entry_count(entry_count),
		.bytes_used(bytes_used),
		.last(last)
	);

	always #1 clk = ~clk;

	// Predictor copy of the table. Rank 0 is the most recently inserted entry;
	// valid slots always hold the ranks 0 .. held_n-1.
	logic [31:0] tag_q [NUM_SLOTS];
	logic [31:0] size_q [NUM_SLOTS];
	bit          valid_q [NUM_SLOTS];
	int unsigned rank_q [NUM_SLOTS];
	int unsigned held_n = 0;
	logic [31:0] held_sz = '0;
	logic [31:0] budget = CAPACITY_RESET;

	cache_result_t expected_outcomes[$];
	cache_result_t oldest_outcome;
	logic [31:0]   key_pool [24];
	int            error_count = 0;
	int            quiet_cycles = 0;

	initial begin
		foreach (valid_q[i])
			valid_q[i] = 1'b0;
	end

	function automatic int slot_of_key(logic [31:0] k);
		for (int i = 0; i < NUM_SLOTS; i++)
			if (valid_q[i] && tag_q[i] == k)
				return i;
		return -1;
	endfunction

	// The least recent entry carries the highest rank.
	function automatic int oldest_slot();
		int found;
		found = -1;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (valid_q[i] && (found < 0 || rank_q[i] > rank_q[found]))
				found = i;
		return found;
	endfunction

	// Removing an entry closes the gap in the ranks behind it.
	function automatic void drop_slot(int s);
		for (int i = 0; i < NUM_SLOTS; i++)
			if (valid_q[i] && rank_q[i] > rank_q[s])
				rank_q[i]--;
		valid_q[s] = 1'b0;
		held_n--;
		held_sz -= size_q[s];
	endfunction

	// Queues one outcome, taking the count and bytes held at this point.
	function automatic void queue_outcome(logic h, logic rej, logic ev, logic [31:0] ev_key,
		logic fin);
		cache_result_t r;
		r.hit = h;
		r.rejected = rej;
		r.evicted_valid = ev;
		r.evicted_key = ev ? ev_key : 32'd0;
		r.entry_count = 5'(held_n);
		r.bytes_used = held_sz;
		r.last = fin;
		expected_outcomes.push_back(r);
	endfunction

	// Applies one accepted request to the predictor and queues what it must report.
	function automatic void apply_cache_request(logic [1:0] m, logic [31:0] k, logic [31:0] sz);
		int s;
		case (m)
			MODE_LOOKUP: begin
				queue_outcome(slot_of_key(k) >= 0, 1'b0, 1'b0, 32'd0, 1'b1);
			end
			MODE_CLEAR: begin
				foreach (valid_q[i])
					valid_q[i] = 1'b0;
				held_n = 0;
				held_sz = '0;
				queue_outcome(1'b0, 1'b0, 1'b0, 32'd0, 1'b1);
			end
			MODE_INSERT: begin
				if (sz > budget) begin
					queue_outcome(1'b0, 1'b1, 1'b0, 32'd0, 1'b1);
				end else begin
					// An update drops the old copy without reporting it.
					s = slot_of_key(k);
					if (s >= 0)
						drop_slot(s);
					// Evict from the cold end until the new entry fits; the sum is
					// taken one bit wider so that it cannot wrap.
					while (({1'b0, held_sz} + {1'b0, sz}) > {1'b0, budget}) begin
						s = oldest_slot();
						if (s < 0)
							break;
						drop_slot(s);
						queue_outcome(1'b0, 1'b0, 1'b1, tag_q[s], 1'b0);
					end
					// A full table gives up one more entry even when the bytes fit.
					if (held_n >= NUM_SLOTS) begin
						s = oldest_slot();
						if (s >= 0) begin
							drop_slot(s);
							queue_outcome(1'b0, 1'b0, 1'b1, tag_q[s], 1'b0);
						end
					end
					// The new entry takes the lowest free slot and the newest rank.
					s = 0;
					while (s < NUM_SLOTS && valid_q[s])
						s++;
					if (s < NUM_SLOTS) begin
						for (int i = 0; i < NUM_SLOTS; i++)
							if (valid_q[i])
								rank_q[i]++;
						valid_q[s] = 1'b1;
						tag_q[s] = k;
						size_q[s] = sz;
						rank_q[s] = 0;
						held_n++;
						held_sz += sz;
					end
					queue_outcome(1'b0, 1'b0, 1'b0, 32'd0, 1'b1);
				end
			end
			default: begin
				// The spare code changes nothing and reports all flags low but last.
				queue_outcome(1'b0, 1'b0, 1'b0, 32'd0, 1'b1);
			end
		endcase
	endfunction

	// Presents one request from the falling edge and holds it until the block
	// takes it. The predictor runs at the accepting edge, ahead of the first result.
	task automatic send_request(input logic [1:0] m, input logic [31:0] k,
		input logic [31:0] sz);
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		key <= k;
		entry_size <= sz;
		do
			@(posedge clk);
		while (busy);
		apply_cache_request(m, k, sz);
	endtask

	// Leaves start low over the gap given by n. The request fields carry junk
	// meanwhile, which the block must ignore.
	task automatic hold_off(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			mode <= 2'($urandom);
			key <= $urandom;
			entry_size <= $urandom;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// Stops sending and waits until every queued outcome has been seen.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// The budget is only rewritten while the block is idle.
	task automatic set_budget(input logic [31:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= $urandom;
		budget = v;
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Sizes are mostly a small share of the budget so that several entries
	// fit and byte evictions happen; the rest are zero, the budget, one past it or random.
	function automatic logic [31:0] pick_size(logic [31:0] cap);
		int r;
		r = $urandom_range(99, 0);
		if (r < 5)
			return 32'd0;
		if (r < 10)
			return cap;
		if (r < 15)
			return cap + 32'd1;
		if (r < 22)
			return $urandom;
		return $urandom_range(cap / 6, 0);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Each strobed result is matched against the oldest outstanding outcome.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual key %h",
					$time, evicted_key);
				error_count++;
			end else begin
				oldest_outcome = expected_outcomes.pop_front();
				check_field("hit", 32'(oldest_outcome.hit), 32'(hit));
				check_field("rejected", 32'(oldest_outcome.rejected), 32'(rejected));
				check_field("evicted_valid", 32'(oldest_outcome.evicted_valid),
					32'(evicted_valid));
				check_field("evicted_key", oldest_outcome.evicted_key, evicted_key);
				check_field("entry_count", 32'(oldest_outcome.entry_count), 32'(entry_count));
				check_field("bytes_used", oldest_outcome.bytes_used, bytes_used);
				check_field("last", 32'(oldest_outcome.last), 32'(last));
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles that move nothing.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Hand-picked requests at the reset budget: miss on an empty table, zero
	// size, an entry exactly as large as the budget, a rejected insert, an
	// insert that evicts twice, an update, the spare code, a full table that
	// forces an eviction even though the bytes fit, and a clear.
	task automatic test_directed_cases();
		send_request(MODE_LOOKUP, 32'h1234_5678, 32'd0);
		send_request(MODE_INSERT, 32'h0000_0000, 32'd0);
		send_request(MODE_INSERT, 32'hFFFF_FFFF, CAPACITY_RESET);
		send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(MODE_INSERT, 32'h0000_0005, CAPACITY_RESET + 32'd1);
		send_request(MODE_INSERT, 32'h0000_0005, 32'd1);
		send_request(MODE_INSERT, 32'h0000_0005, 32'd10);
		send_request(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < NUM_SLOTS - 1; i++)
			send_request(MODE_INSERT, 32'h100 + i, 32'd0);
		send_request(MODE_INSERT, 32'h0000_0200, 32'd0);
		send_request(MODE_CLEAR, 32'h0000_0200, 32'd0);
		send_request(MODE_LOOKUP, 32'h0000_0200, 32'd0);
		wait_drained();
	endtask

	// Lowering the budget below what is held evicts nothing until the next
	// insert, which then evicts until its own entry fits.
	task automatic test_budget_lowered();
		set_budget(32'd1000);
		for (int i = 0; i < 4; i++)
			send_request(MODE_INSERT, 32'hA0 + i, 32'd200);
		set_budget(32'd300);
		send_request(MODE_LOOKUP, 32'hA0, 32'd0);
		send_request(MODE_INSERT, 32'hB0, 32'd100);
		send_request(MODE_LOOKUP, 32'hA3, 32'd0);
		wait_drained();
	endtask

	// Random traffic under one budget. Keys come mostly from a small pool so
	// that hits, updates and evictions of known keys are frequent. Gaps come
	// in stretches, with every third stretch sent back to back.
	task automatic test_random_traffic(input logic [31:0] cap, input int n_items);
		int          r;
		logic [1:0]  m;
		logic [31:0] k;
		set_budget(cap);
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 24; i++)
			key_pool[i] = $urandom;
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(99, 0);
			if (r < 50)
				m = MODE_INSERT;
			else if (r < 95)
				m = MODE_LOOKUP;
			else if (r < 97)
				m = MODE_CLEAR;
			else
				m = MODE_UNUSED;
			k = ($urandom_range(99, 0) < 85) ? key_pool[$urandom_range(23, 0)] : $urandom;
			send_request(m, k, (m == MODE_INSERT) ? pick_size(cap) : $urandom);
			if ((n / 20) % 3 != 0)
				hold_off(pick_gap());
			// Now and then the sender waits for every outstanding result.
			if ($urandom_range(49, 0) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_budget_lowered();
		test_random_traffic(CAPACITY_RESET, 88);
		test_random_traffic(32'd0, 88);
		test_random_traffic(32'hFFFF_FFFF, 88);
		test_random_traffic($urandom_range(4096, 64), 88);
		test_random_traffic($urandom, 88);
		wait_drained();
		repeat (24)
			@(posedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
